### hw/rtl/rrts_pkg.sv
// Shared types and constants of the round-robin thread slot scheduler.
// Used by rrts_ctrl, rrts_dp and the top level of hw/rtl; depends on nothing.
`default_nettype none

package rrts_pkg;

	localparam int SLOTS_DEF      = 4;
	localparam int FRAME_SHIFT    = 4;
	localparam int PTR_W          = 8;
	localparam logic [7:0] FRAME_BYTES    = 8'd15;
	localparam logic [7:0] STACK_BASE_RST = 8'h40;

	localparam logic [1:0] OP_CREATE = 2'd0;
	localparam logic [1:0] OP_SWITCH = 2'd1;
	localparam logic [1:0] OP_EXIT   = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_FREE = 2'd1;
	localparam logic [1:0] ST_NO_LIVE = 2'd2;

	typedef struct packed {
		logic capture;
		logic create;
		logic save;
		logic clear_run;
		logic scan_init;
		logic scan_step;
		logic take_cand;
		logic load_rd;
		logic fin_nop;
		logic fin_no_free;
		logic fin_no_live;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_create;
		logic is_switch;
		logic is_exit;
		logic no_free;
		logic no_live;
		logic exit_empties;
		logic cand_live;
	} dp_stat_t;

endpackage

`default_nettype wire

### hw/rtl/rrts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module rrts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/rrts_ctrl.sv
// Controller state machine of the scheduler: sequences capture, execute,
// slot scan, pointer read and result strobe. Depends on rrts_pkg.
`default_nettype none

module rrts_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire rrts_pkg::dp_stat_t stat,
	output      rrts_pkg::ctrl_cmd_t cmd,
	output      logic               busy,
	output      logic               done
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_READ = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign busy   = (state_q != S_IDLE) && (state_q != S_DONE);
	assign done   = (state_q == S_DONE);
	assign accept = start && !busy;

	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		cmd.capture = accept;
		unique case (state_q)
			S_IDLE, S_DONE: begin
				state_d = accept ? S_EXEC : S_IDLE;
			end
			S_EXEC: begin
				state_d = S_DONE;
				if (stat.is_create) begin
					if (stat.no_free) begin
						cmd.fin_no_free = 1'b1;
					end else begin
						cmd.create = 1'b1;
					end
				end else if (stat.is_switch) begin
					if (stat.no_live) begin
						cmd.fin_no_live = 1'b1;
					end else begin
						cmd.save      = 1'b1;
						cmd.scan_init = 1'b1;
						state_d       = S_SCAN;
					end
				end else if (stat.is_exit) begin
					cmd.clear_run = 1'b1;
					if (stat.exit_empties) begin
						cmd.fin_no_live = 1'b1;
					end else begin
						cmd.scan_init = 1'b1;
						state_d       = S_SCAN;
					end
				end else begin
					cmd.fin_nop = 1'b1;
				end
			end
			S_SCAN: begin
				if (stat.cand_live) begin
					cmd.take_cand = 1'b1;
					state_d       = S_READ;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_READ: begin
				cmd.load_rd = 1'b1;
				state_d     = S_DONE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted transfer did not raise busy");

	a_read_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_cand |=> (cmd.load_rd ##1 done))
		else $error("pointer read not followed by result strobe");

endmodule

`default_nettype wire

### hw/rtl/rrts_dp.sv
// Datapath of the scheduler: live mask, running slot, scan candidate,
// stack base register, saved pointer RAM and result registers.
// Depends on rrts_pkg and rrts_ram.
`default_nettype none

module rrts_dp #(
	parameter int SLOTS = rrts_pkg::SLOTS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wr_en,
	input  wire logic [7:0]                cfg_wr_data,
	input  wire logic [1:0]                opcode,
	input  wire logic [7:0]                stack_ptr_now,
	input  wire rrts_pkg::ctrl_cmd_t       cmd,
	output      rrts_pkg::dp_stat_t        stat,
	output      logic [1:0]                status,
	output      logic [1:0]                slot_id,
	output      logic [7:0]                stack_ptr_out
);

	localparam int SW = $clog2(SLOTS);
	localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

	logic [SLOTS-1:0] live_q;
	logic [SW-1:0]    running_q;
	logic [SW-1:0]    cand_q;
	logic [7:0]       stack_base_q;
	logic [1:0]       op_q;
	logic [7:0]       sp_now_q;
	logic [1:0]       status_q;
	logic [SW-1:0]    slot_q;
	logic [7:0]       sp_out_q;

	logic [SW-1:0]    free_idx;
	logic [SLOTS-1:0] run_mask;
	logic [SLOTS-1:0] live_after_exit;
	logic [SW-1:0]    run_next;
	logic [SW-1:0]    cand_next;
	logic [7:0]       frame_ptr;
	logic             ram_we;
	logic [SW-1:0]    ram_waddr;
	logic [7:0]       ram_wdata;
	logic [7:0]       ram_rdata;

	always_comb begin
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!live_q[i]) begin
				free_idx = SW'(i);
			end
		end
	end

	assign run_mask        = SLOTS'(1) << running_q;
	assign live_after_exit = live_q & ~run_mask;
	assign run_next        = (running_q == LAST_SLOT) ? '0 : running_q + 1'b1;
	assign cand_next       = (cand_q == LAST_SLOT) ? '0 : cand_q + 1'b1;
	assign frame_ptr       = stack_base_q + ((8'(free_idx)) << rrts_pkg::FRAME_SHIFT)
		+ rrts_pkg::FRAME_BYTES;

	assign stat.is_create    = (op_q == rrts_pkg::OP_CREATE);
	assign stat.is_switch    = (op_q == rrts_pkg::OP_SWITCH);
	assign stat.is_exit      = (op_q == rrts_pkg::OP_EXIT);
	assign stat.no_free      = &live_q;
	assign stat.no_live      = (live_q == '0);
	assign stat.exit_empties = (live_after_exit == '0);
	assign stat.cand_live    = live_q[cand_q];

	assign ram_we    = cmd.create || cmd.save;
	assign ram_waddr = cmd.create ? free_idx : running_q;
	assign ram_wdata = cmd.create ? frame_ptr : sp_now_q;

	rrts_ram #(
		.WIDTH(rrts_pkg::PTR_W),
		.DEPTH(SLOTS)
	) u_sp_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.take_cand),
		.raddr(cand_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q       <= '0;
			running_q    <= '0;
			stack_base_q <= rrts_pkg::STACK_BASE_RST;
		end else begin
			if (cfg_wr_en) begin
				stack_base_q <= cfg_wr_data;
			end
			if (cmd.create) begin
				live_q <= live_q | (SLOTS'(1) << free_idx);
			end else if (cmd.clear_run) begin
				live_q <= live_after_exit;
			end
			if (cmd.take_cand) begin
				running_q <= cand_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= opcode;
			sp_now_q <= stack_ptr_now;
		end
		if (cmd.scan_init) begin
			cand_q <= run_next;
		end else if (cmd.scan_step) begin
			cand_q <= cand_next;
		end
		if (cmd.create) begin
			status_q <= rrts_pkg::ST_OK;
			slot_q   <= free_idx;
			sp_out_q <= frame_ptr;
		end else if (cmd.fin_no_free) begin
			status_q <= rrts_pkg::ST_NO_FREE;
			slot_q   <= '0;
			sp_out_q <= '0;
		end else if (cmd.fin_no_live) begin
			status_q <= rrts_pkg::ST_NO_LIVE;
			slot_q   <= running_q;
			sp_out_q <= '0;
		end else if (cmd.fin_nop) begin
			status_q <= rrts_pkg::ST_OK;
			slot_q   <= running_q;
			sp_out_q <= '0;
		end else if (cmd.take_cand) begin
			status_q <= rrts_pkg::ST_OK;
			slot_q   <= cand_q;
		end else if (cmd.load_rd) begin
			sp_out_q <= ram_rdata;
		end
	end

	assign status        = status_q;
	assign slot_id       = 2'(slot_q);
	assign stack_ptr_out = sp_out_q;

	a_scan_has_live: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_step || cmd.scan_init) |-> (live_q != '0))
		else $error("slot scan started or advanced with no live slot");

	a_take_sets_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_cand |=> (running_q == $past(cand_q)))
		else $error("running slot not updated from scan result");

	a_create_marks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.create |=> live_q[$past(free_idx)])
		else $error("created slot not marked live");

endmodule

`default_nettype wire

### hw/rtl/round_robin_thread_slot_scheduler.sv
// Top level of the round-robin thread slot scheduler.
// Joins rrts_ctrl and rrts_dp; depends on rrts_pkg.
//
// A command is taken when start is high and busy is low; its result appears
// on status, slot_id and stack_ptr_out for exactly the one cycle in which done
// is high, and must be captured then since it cannot be held off. Create, a
// no-op, and any command that fails with no free or no live slot go from the
// execute state straight to done. Switch and exit scan the slots one per
// cycle, starting after the running slot, then read the saved pointer from the
// slot RAM in the read state before done; the scan distance to the next live
// slot sets how long the scan state lasts. A new command may be accepted in
// the cycle done is high. The user must write stack_base through cfg_wr_en and
// cfg_wr_data only while no command is in flight; the block does not enforce it.
`default_nettype none

module round_robin_thread_slot_scheduler #(
	parameter int SLOTS = rrts_pkg::SLOTS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data,
	input  wire logic       start,
	output      logic       busy,
	input  wire logic [1:0] opcode,
	input  wire logic [7:0] stack_ptr_now,
	output      logic       done,
	output      logic [1:0] status,
	output      logic [1:0] slot_id,
	output      logic [7:0] stack_ptr_out
);

	rrts_pkg::ctrl_cmd_t cmd;
	rrts_pkg::dp_stat_t  stat;

	rrts_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	rrts_dp #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.opcode       (opcode),
		.stack_ptr_now(stack_ptr_now),
		.cmd          (cmd),
		.stat         (stat),
		.status       (status),
		.slot_id      (slot_id),
		.stack_ptr_out(stack_ptr_out)
	);

endmodule

`default_nettype wire
